// ===== design/icsa_pkg.sv =====
// shared types and constants for the ignition coil slope adaptation block
package icsa_pkg;

  localparam int NUM_COILS = 8;
  localparam int COIL_W    = 3;
  localparam int TIME_W    = 32;
  localparam int VOLT_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = TIME_W + CFG_W;
  localparam int DIVD_W    = 53;
  localparam int DSR_W     = 32;
  localparam int NUM_W     = 53;
  localparam int NDIFF_W   = 52;

  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FACTOR_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_POWER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_MUL    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_DIV    = 3'd7;

  localparam logic [CFG_W-1:0] RST_FACTOR_MIN  = 16'd0;
  localparam logic [CFG_W-1:0] RST_FACTOR_MAX  = 16'hFFFF;
  localparam logic [CFG_W-1:0] RST_FACTOR_STEP = 16'd1;
  localparam logic [CFG_W-1:0] RST_OFFSET_STEP = 16'd1;
  localparam logic [CFG_W-1:0] RST_TIME_MUL    = 16'd1;
  localparam logic [CFG_W-1:0] RST_TIME_DIV    = 16'd32;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/icsa_div.sv =====
// shared restoring divider, one quotient bit per cycle
module icsa_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [icsa_pkg::DIVD_W-1:0]    dividend,
  input  logic [icsa_pkg::DSR_W-1:0]     divisor,
  output logic [icsa_pkg::DIVD_W-1:0]    quotient,
  output icsa_pkg::div_stat_t            stat
);

  localparam int DW    = icsa_pkg::DIVD_W;
  localparam int SW    = icsa_pkg::DSR_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DW-1:0]     quo_r;
  logic [SW-1:0]     rem_r;
  logic [SW-1:0]     dsr_r;
  logic [SW+1:0]     trial;

  assign trial = {1'b0, rem_r, quo_r[DW-1]} - {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      if (trial[SW+1]) begin
        rem_r <= {rem_r[SW-2:0], quo_r[DW-1]};
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end else begin
        rem_r <= trial[SW-1:0];
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== design/ignition_coil_slope_adapt.sv =====
// top level of the per-coil ignition slope adaptation block
//
// usage:
//   in_* channel: one slope measurement beat per item (coil, two times,
//   two voltages, valid and fault flags); accepted when in_valid and
//   in_ready are high at a rising edge
//   out_* channel: one result beat per item, with the coil's stored factor,
//   stored offset, sticky converged flag and an updated flag
//   cfg_* channel: register writes, always ready, index 0 to 7
// item processing:
//   an item that updates runs four divisions on one shared restoring
//   divider (53 iterations each) and one shared 32x16 multiplier; a
//   division with a zero divisor is skipped; an item without update goes
//   straight from idle to the output state
//   in_ready is high only while the sequencer is idle, one item at a time
// reset: rst_n low clears the sequencer, config registers to defaults and
//   all per-coil factor, offset and converged entries to zero
// stall: a result waits in the output register while out_ready is low; the
//   next item is accepted meanwhile and holds its result until the
//   register frees
module ignition_coil_slope_adapt (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [icsa_pkg::COIL_W-1:0]       in_coil_index,
  input  logic [icsa_pkg::TIME_W-1:0]       in_time_first,
  input  logic [icsa_pkg::TIME_W-1:0]       in_time_second,
  input  logic [icsa_pkg::VOLT_W-1:0]       in_volt_first,
  input  logic [icsa_pkg::VOLT_W-1:0]       in_volt_second,
  input  logic                              in_acquisition_valid,
  input  logic                              in_short_fault,
  input  logic                              in_open_fault,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [icsa_pkg::COIL_W-1:0]       out_coil_out,
  output logic [15:0]                       out_stored_factor,
  output logic signed [15:0]                out_stored_offset,
  output logic                              out_converged,
  output logic                              out_updated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [icsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [icsa_pkg::CFG_W-1:0]        cfg_data
);

  localparam int NC  = icsa_pkg::NUM_COILS;
  localparam int CW  = icsa_pkg::COIL_W;
  localparam int TW  = icsa_pkg::TIME_W;
  localparam int VW  = icsa_pkg::VOLT_W;
  localparam int FW  = icsa_pkg::CFG_W;
  localparam int PW  = icsa_pkg::PROD_W;
  localparam int DW  = icsa_pkg::DIVD_W;
  localparam int SW  = icsa_pkg::DSR_W;
  localparam int NW  = icsa_pkg::NUM_W;
  localparam int XW  = icsa_pkg::NDIFF_W;

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_T1, S_GO_T1, S_WAIT_T1, S_MUL_T2, S_GO_T2, S_WAIT_T2,
    S_DIFF, S_MUL_A, S_MUL_B, S_NSUB, S_NADD, S_GO_F, S_WAIT_F,
    S_GO_O, S_WAIT_O, S_SLEW, S_OUT
  } state_t;

  state_t state_r;

  // config registers
  logic [FW-1:0] fmin_r, fmax_r, fstep_r, ostep_r, tmul_r, tdiv_r;
  logic          test_r, ext_r;

  // item registers
  logic [CW-1:0] coil_r;
  logic [TW-1:0] t1_r, t2_r;
  logic [VW-1:0] v1_r, v2_r;
  logic          go_r, bad_r;

  // datapath registers
  logic [PW-1:0]        prod_r, pa_r;
  logic [TW-1:0]        ts1_r, ts2_r, dt_r;
  logic [VW-1:0]        dv_r;
  logic signed [XW-1:0] n_r;
  logic signed [NW-1:0] num_r;
  logic [15:0]          ifac_r;
  logic signed [15:0]   ioff_r;

  // per-coil state
  logic [15:0]        fac_mem_r [NC];
  logic signed [15:0] off_mem_r [NC];
  logic [NC-1:0]      conv_r;

  // output register
  logic               out_valid_r;
  logic [CW-1:0]      out_coil_r;
  logic [15:0]        out_fac_r;
  logic signed [15:0] out_off_r;
  logic               out_conv_r;
  logic               out_upd_r;

  // shared multiplier
  logic [TW-1:0] mul_a;
  logic [FW-1:0] mul_b;
  logic [PW-1:0] prod;

  always_comb begin
    case (state_r)
      S_MUL_T1: begin mul_a = t1_r;  mul_b = tmul_r; end
      S_MUL_T2: begin mul_a = t2_r;  mul_b = tmul_r; end
      S_MUL_A:  begin mul_a = ts2_r; mul_b = v1_r;   end
      S_MUL_B:  begin mul_a = ts1_r; mul_b = v2_r;   end
      default:  begin mul_a = '0;    mul_b = '0;     end
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // shared divider
  logic                div_start;
  logic [DW-1:0]       div_dvd;
  logic [SW-1:0]       div_dsr;
  logic [DW-1:0]       div_quo;
  icsa_pkg::div_stat_t div_stat;
  logic [DW-1:0]       fnum;
  logic [DW-1:0]       omag;

  assign fnum = {12'b0, dt_r, 9'b0} + {37'b0, dv_r};
  assign omag = num_r[NW-1] ? DW'(-num_r) : DW'(num_r);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    case (state_r)
      S_GO_T1, S_GO_T2: begin
        div_start = (tdiv_r != '0);
        div_dvd   = {5'b0, prod_r};
        div_dsr   = {16'b0, tdiv_r};
      end
      S_GO_F: begin
        div_start = (dv_r != '0);
        div_dvd   = fnum;
        div_dsr   = {15'b0, dv_r, 1'b0};
      end
      S_GO_O: begin
        div_start = (dt_r != '0);
        div_dvd   = omag;
        div_dsr   = dt_r;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  icsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // quotient post-processing
  logic [TW-1:0]      q_time;
  logic [15:0]        q_fsat, q_fmin, q_fac;
  logic               q_big;
  logic signed [15:0] q_off;

  assign q_time = (|div_quo[DW-1:TW]) ? '1 : div_quo[TW-1:0];
  assign q_fsat = (|div_quo[DW-1:16]) ? 16'hFFFF : div_quo[15:0];
  assign q_fmin = (q_fsat < fmin_r) ? fmin_r : q_fsat;
  assign q_fac  = (q_fmin > fmax_r) ? fmax_r : q_fmin;
  assign q_big  = |div_quo[DW-1:15];

  always_comb begin
    if (num_r[NW-1]) begin
      q_off = q_big ? 16'sh8000 : -$signed(div_quo[15:0]);
    end else begin
      q_off = q_big ? 16'sh7FFF : $signed(div_quo[15:0]);
    end
  end

  // slew limiting
  logic [15:0]        f_prev, f_mag, f_new;
  logic [16:0]        f_d;
  logic               f_in;
  logic signed [15:0] o_prev, o_new;
  logic signed [16:0] o_d;
  logic [15:0]        o_mag;
  logic               o_in;

  assign f_prev = fac_mem_r[coil_r];
  assign f_d    = {1'b0, ifac_r} - {1'b0, f_prev};
  assign f_mag  = f_d[16] ? (16'd0 - f_d[15:0]) : f_d[15:0];
  assign f_in   = (f_mag <= fstep_r);
  assign f_new  = f_in ? ifac_r : (f_d[16] ? f_prev - fstep_r : f_prev + fstep_r);

  assign o_prev = off_mem_r[coil_r];
  assign o_d    = {ioff_r[15], ioff_r} - {o_prev[15], o_prev};
  assign o_mag  = o_d[16] ? (16'd0 - o_d[15:0]) : o_d[15:0];
  assign o_in   = (o_mag <= ostep_r);
  assign o_new  = o_in ? ioff_r :
                  (o_d[16] ? o_prev - $signed(ostep_r) : o_prev + $signed(ostep_r));

  logic in_bad, in_go;

  assign in_bad = ({1'b0, in_coil_index} >= (CW + 1)'(NC));
  assign in_go  = !in_bad && !test_r && !ext_r && in_acquisition_valid &&
                  !in_short_fault && !in_open_fault;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fmin_r      <= icsa_pkg::RST_FACTOR_MIN;
      fmax_r      <= icsa_pkg::RST_FACTOR_MAX;
      fstep_r     <= icsa_pkg::RST_FACTOR_STEP;
      ostep_r     <= icsa_pkg::RST_OFFSET_STEP;
      test_r      <= 1'b0;
      ext_r       <= 1'b0;
      tmul_r      <= icsa_pkg::RST_TIME_MUL;
      tdiv_r      <= icsa_pkg::RST_TIME_DIV;
      conv_r      <= '0;
      for (int i = 0; i < NC; i++) begin
        fac_mem_r[i] <= '0;
        off_mem_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          icsa_pkg::REG_FACTOR_MIN:  fmin_r  <= cfg_data;
          icsa_pkg::REG_FACTOR_MAX:  fmax_r  <= cfg_data;
          icsa_pkg::REG_FACTOR_STEP: fstep_r <= cfg_data;
          icsa_pkg::REG_OFFSET_STEP: ostep_r <= cfg_data;
          icsa_pkg::REG_TEST_MODE:   test_r  <= cfg_data[0];
          icsa_pkg::REG_EXT_POWER:   ext_r   <= cfg_data[0];
          icsa_pkg::REG_TIME_MUL:    tmul_r  <= cfg_data;
          icsa_pkg::REG_TIME_DIV:    tdiv_r  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (out_valid_r && out_ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= in_go ? S_MUL_T1 : S_OUT;
          end
        end
        S_MUL_T1: state_r <= S_GO_T1;
        S_GO_T1:  state_r <= (tdiv_r != '0) ? S_WAIT_T1 : S_MUL_T2;
        S_WAIT_T1: begin
          if (div_stat.done) begin
            state_r <= S_MUL_T2;
          end
        end
        S_MUL_T2: state_r <= S_GO_T2;
        S_GO_T2:  state_r <= (tdiv_r != '0) ? S_WAIT_T2 : S_DIFF;
        S_WAIT_T2: begin
          if (div_stat.done) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF:  state_r <= S_MUL_A;
        S_MUL_A: state_r <= S_MUL_B;
        S_MUL_B: state_r <= S_NSUB;
        S_NSUB:  state_r <= S_NADD;
        S_NADD:  state_r <= S_GO_F;
        S_GO_F:  state_r <= (dv_r != '0) ? S_WAIT_F : S_GO_O;
        S_WAIT_F: begin
          if (div_stat.done) begin
            state_r <= S_GO_O;
          end
        end
        S_GO_O: state_r <= (dt_r != '0) ? S_WAIT_O : S_SLEW;
        S_WAIT_O: begin
          if (div_stat.done) begin
            state_r <= S_SLEW;
          end
        end
        S_SLEW: begin
          fac_mem_r[coil_r] <= f_new;
          off_mem_r[coil_r] <= o_new;
          if (f_in && o_in) begin
            conv_r[coil_r] <= 1'b1;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_coil_r  <= coil_r;
            out_upd_r   <= go_r;
            if (bad_r) begin
              out_fac_r  <= '0;
              out_off_r  <= '0;
              out_conv_r <= 1'b0;
            end else begin
              out_fac_r  <= fac_mem_r[coil_r];
              out_off_r  <= off_mem_r[coil_r];
              out_conv_r <= conv_r[coil_r];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          coil_r <= in_coil_index;
          t1_r   <= in_time_first;
          t2_r   <= in_time_second;
          v1_r   <= in_volt_first;
          v2_r   <= in_volt_second;
          go_r   <= in_go;
          bad_r  <= in_bad;
        end
      end
      S_MUL_T1, S_MUL_T2, S_MUL_A: prod_r <= prod;
      S_GO_T1: begin
        if (tdiv_r == '0) begin
          ts1_r <= '1;
        end
      end
      S_WAIT_T1: begin
        if (div_stat.done) begin
          ts1_r <= q_time;
        end
      end
      S_GO_T2: begin
        if (tdiv_r == '0) begin
          ts2_r <= '1;
        end
      end
      S_WAIT_T2: begin
        if (div_stat.done) begin
          ts2_r <= q_time;
        end
      end
      S_DIFF: begin
        dv_r <= (v2_r > v1_r) ? v2_r - v1_r : '0;
        dt_r <= (ts2_r > ts1_r) ? ts2_r - ts1_r : '0;
      end
      S_MUL_B: begin
        pa_r   <= prod_r;
        prod_r <= prod;
      end
      S_NSUB: n_r <= $signed({({1'b0, pa_r} - {1'b0, prod_r}), 3'b000});
      S_NADD: num_r <= {n_r[XW-1], n_r} + $signed({22'b0, dt_r[TW-1:1]});
      S_GO_F: begin
        if (dv_r == '0) begin
          ifac_r <= fmax_r;
        end
      end
      S_WAIT_F: begin
        if (div_stat.done) begin
          ifac_r <= q_fac;
        end
      end
      S_GO_O: begin
        if (dt_r == '0) begin
          ioff_r <= n_r[XW-1] ? 16'sh8000 : 16'sh7FFF;
        end
      end
      S_WAIT_O: begin
        if (div_stat.done) begin
          ioff_r <= q_off;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready          = (state_r == S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_coil_out      = out_coil_r;
  assign out_stored_factor = out_fac_r;
  assign out_stored_offset = out_off_r;
  assign out_converged     = out_conv_r;
  assign out_updated       = out_upd_r;

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while sequencer still idle");

  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_WAIT_T1 || state_r == S_WAIT_T2 ||
                       state_r == S_WAIT_F || state_r == S_WAIT_O))
    else $error("divider finished outside a wait state");

  a_slew_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SLEW) |-> (go_r && !bad_r))
    else $error("store update without enabled item");
`endif

endmodule
